// ----- sv/sks_pkg.sv -----
package sks_pkg;

  localparam int KEY_W  = 8;
  localparam int ROW_W  = 4;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 3;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CLEARED   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_QUERIED   = 3'd5;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [ROW_W-1:0]  row;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              present;
    logic [CNT_W-1:0]  count;
    logic [KEY_W-1:0]  row_value;
    logic              row_valid;
  } out_word_t;

  // per-cycle commands broadcast along the chain
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ----- sv/sks_cell.sv -----
module sks_cell #(
  parameter int KEY_BITS = 8
) (
  input  logic                  clk,
  input  sks_pkg::cell_ctl_t    ctl,
  input  logic [KEY_BITS-1:0]   op_key,
  input  logic                  valid,
  input  logic                  prev_lt,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [KEY_BITS-1:0]   next_key,
  output logic [KEY_BITS-1:0]   key_o,
  output logic                  lt_o,
  output logic                  eq_o,
  output logic                  eq1_o
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                lt_r, eq_r, eq1_r;
  logic [KEY_BITS:0]   key_plus1;

  assign key_plus1 = {1'b0, op_key} + {{KEY_BITS{1'b0}}, 1'b1};

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins && !lt_r) begin
      // below the insertion place keep, at it take the new key, above it shift up
      key_nxt = prev_lt ? op_key : prev_key;
    end else if (ctl.rem && !lt_r) begin
      key_nxt = next_key - {{(KEY_BITS-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctl.cmp) begin
      lt_r  <= valid && (key_r < op_key);
      eq_r  <= valid && (key_r == op_key);
      eq1_r <= valid && ({1'b0, key_r} == key_plus1);
    end
  end

  assign key_o = key_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;
  assign eq1_o = eq1_r;

endmodule

// ----- sv/sorted_key_set_with_renumber.sv -----
// Sorted key set with renumbering on removal.
// Input channel in_valid/in_ready/in_word carries one operation word: add,
// remove, clear or query of a key, plus a row whose stored key is reported.
// Output channel out_valid/out_ready/out_word returns exactly one result word
// per operation: status, presence after the operation, count, and the key at
// the requested row with its valid flag.
// Keys sit in a chain of cells, one key per cell, in ascending order. Every
// cell compares its key with the operation key in parallel; an insert shifts
// the cells above the place up by one, a remove pulls them down by one and
// decrements them.
// The result word is registered after the compare, update and row-read steps
// that follow the accepted operation. One operation is in flight at a time,
// so the block takes no new word until the result of the last one is loaded.
// A stalled receiver holds the result in the output register; the block then
// accepts one more operation and waits in the row-read step until the output
// register frees up.
// Reset (rst_n low, synchronous) empties the set; cell contents are not
// cleared and are never read before being written.
module sorted_key_set_with_renumber #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sks_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sks_pkg::out_word_t  out_word
);

  localparam int HW = $clog2(DEPTH + 1);
  localparam int XW = (KEY_BITS > sks_pkg::KEY_W) ? KEY_BITS : sks_pkg::KEY_W;
  localparam int CW = (HW > sks_pkg::CNT_W) ? HW : sks_pkg::CNT_W;
  localparam int RN = (DEPTH < (1 << sks_pkg::ROW_W)) ? DEPTH : (1 << sks_pkg::ROW_W);
  localparam int RW = (HW > sks_pkg::ROW_W) ? HW : sks_pkg::ROW_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_RD   = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [HW-1:0]                held_r, held_nxt;
  sks_pkg::in_word_t            op_r;
  logic [KEY_BITS-1:0]          op_key;
  logic [XW-1:0]                key_ext;
  logic [sks_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic                         present_r, present_nxt;
  logic                         out_valid_r;
  sks_pkg::out_word_t           out_word_r, out_word_nxt;
  sks_pkg::cell_ctl_t           ctl;

  logic [KEY_BITS-1:0] key_v  [DEPTH];
  logic [KEY_BITS-1:0] prev_key_v [DEPTH];
  logic [KEY_BITS-1:0] next_key_v [DEPTH];
  logic [DEPTH-1:0]    lt_v, eq_v, eq1_v, valid_v, prev_lt_v;

  logic                in_fire, out_load, found, next_hit, full;
  logic [XW-1:0]       row_key_ext;
  logic [KEY_BITS-1:0] row_key;
  logic [RW-1:0]       row_ext;
  logic [CW-1:0]       cnt_ext;

  assign key_ext = XW'(op_r.key);
  assign op_key  = key_ext[KEY_BITS-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign valid_v[gi] = (HW'(gi) < held_r);
      if (gi == 0) begin : g_first
        assign prev_lt_v[gi]  = 1'b1;
        assign prev_key_v[gi] = key_v[gi];
      end else begin : g_mid
        assign prev_lt_v[gi]  = lt_v[gi-1];
        assign prev_key_v[gi] = key_v[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_key_v[gi] = key_v[gi];
      end else begin : g_inner
        assign next_key_v[gi] = key_v[gi+1];
      end
      sks_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .op_key   (op_key),
        .valid    (valid_v[gi]),
        .prev_lt  (prev_lt_v[gi]),
        .prev_key (prev_key_v[gi]),
        .next_key (next_key_v[gi]),
        .key_o    (key_v[gi]),
        .lt_o     (lt_v[gi]),
        .eq_o     (eq_v[gi]),
        .eq1_o    (eq1_v[gi])
      );
    end
  endgenerate

  assign found    = |eq_v;
  assign next_hit = |eq1_v;
  assign full     = (held_r >= HW'(DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_RD) && (!out_valid_r || out_ready);

  always_comb begin
    ctl         = '0;
    held_nxt    = held_r;
    status_nxt  = status_r;
    present_nxt = present_r;
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_RD;
        case (op_r.func)
          sks_pkg::FUNC_ADD: begin
            if (found) begin
              status_nxt  = sks_pkg::STAT_PRESENT;
              present_nxt = 1'b1;
            end else if (full) begin
              status_nxt  = sks_pkg::STAT_FULL;
              present_nxt = 1'b0;
            end else begin
              ctl.ins     = 1'b1;
              held_nxt    = held_r + HW'(1);
              status_nxt  = sks_pkg::STAT_ADDED;
              present_nxt = 1'b1;
            end
          end
          sks_pkg::FUNC_REMOVE: begin
            if (found) begin
              ctl.rem     = 1'b1;
              held_nxt    = held_r - HW'(1);
              status_nxt  = sks_pkg::STAT_REMOVED;
              // the next key renumbers onto the removed one
              present_nxt = next_hit;
            end else begin
              status_nxt  = sks_pkg::STAT_NOT_FOUND;
              present_nxt = 1'b0;
            end
          end
          sks_pkg::FUNC_CLEAR: begin
            held_nxt    = '0;
            status_nxt  = sks_pkg::STAT_CLEARED;
            present_nxt = 1'b0;
          end
          default: begin
            status_nxt  = sks_pkg::STAT_QUERIED;
            present_nxt = found;
          end
        endcase
      end
      ST_RD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // row read after the update has landed in the cells
  always_comb begin
    row_key = '0;
    for (int j = 0; j < RN; j++) begin
      if (sks_pkg::ROW_W'(j) == op_r.row) begin
        row_key = key_v[j];
      end
    end
  end

  assign row_key_ext = XW'(row_key);
  assign row_ext     = RW'(op_r.row);
  assign cnt_ext     = CW'(held_r);

  always_comb begin
    out_word_nxt           = '0;
    out_word_nxt.status    = status_r;
    out_word_nxt.present   = present_r;
    out_word_nxt.count     = cnt_ext[sks_pkg::CNT_W-1:0];
    out_word_nxt.row_valid = (row_ext < RW'(held_r));
    if (out_word_nxt.row_valid) begin
      out_word_nxt.row_value = row_key_ext[sks_pkg::KEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    present_r <= present_nxt;
    if (in_fire) begin
      op_r <= in_word;
    end
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(DEPTH))
    else $error("held count beyond depth");

  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_CMP)
    else $error("accepted word did not start compare");

  a_held_upd: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> $past(state_r) == ST_UPD)
    else $error("count changed outside update step");

  a_out_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RD)
    else $error("result raised outside row read");

  // a later operation may change the count while a full result waits
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_word_nxt.status == sks_pkg::STAT_FULL)
      |-> held_r == HW'(DEPTH))
    else $error("full reported with room left");

endmodule

// ----- sim/sks_checker.sv -----
`timescale 1ns / 100ps

module sks_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sks_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sks_pkg::out_word_t out_word,
  output int                 fails,
  output int                 pending
);

  localparam int SLOTS = 16;

  logic [sks_pkg::KEY_W-1:0] keys [SLOTS];
  logic [sks_pkg::CNT_W-1:0] held;
  sks_pkg::out_word_t        results_due [$];

  // number of held keys strictly below k, i.e. the sorted insertion point
  function automatic int slot_for(logic [sks_pkg::KEY_W-1:0] k);
    int n;
    n = 0;
    for (int i = 0; i < int'(held); i++) begin
      if (keys[i] < k) n++;
    end
    return n;
  endfunction

  function automatic logic key_held(logic [sks_pkg::KEY_W-1:0] k);
    int p;
    p = slot_for(k);
    return (p < int'(held)) && (keys[p] == k);
  endfunction

  function automatic sks_pkg::out_word_t set_apply(sks_pkg::in_word_t w);
    sks_pkg::out_word_t r;
    int                 p;
    int                 i;
    r = '0;
    case (w.func)
      sks_pkg::FUNC_ADD: begin
        // a held key wins over the full test
        if (key_held(w.key)) begin
          r.status = sks_pkg::STAT_PRESENT;
        end else if (int'(held) >= SLOTS) begin
          r.status = sks_pkg::STAT_FULL;
        end else begin
          p = slot_for(w.key);
          for (i = int'(held); i > p; i--) keys[i] = keys[i-1];
          keys[p] = w.key;
          held = held + 1'b1;
          r.status = sks_pkg::STAT_ADDED;
        end
        r.present = key_held(w.key);
      end
      sks_pkg::FUNC_REMOVE: begin
        if (key_held(w.key)) begin
          // close the gap and renumber everything above it
          p = slot_for(w.key);
          for (i = p; i + 1 < int'(held); i++) keys[i] = keys[i+1] - 1'b1;
          held = held - 1'b1;
          r.status = sks_pkg::STAT_REMOVED;
        end else begin
          r.status = sks_pkg::STAT_NOT_FOUND;
        end
        r.present = key_held(w.key);
      end
      sks_pkg::FUNC_CLEAR: begin
        held = '0;
        r.status = sks_pkg::STAT_CLEARED;
        r.present = 1'b0;
      end
      sks_pkg::FUNC_QUERY: begin
        r.status = sks_pkg::STAT_QUERIED;
        r.present = key_held(w.key);
      end
      default: ;
    endcase
    r.count = held;
    if (w.row < held) begin
      r.row_value = keys[w.row];
      r.row_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sks_pkg::out_word_t want;
    if (!rst_n) begin
      held = '0;
      fails = 0;
      results_due.delete();
    end else begin
      if (in_valid && in_ready) results_due.push_back(set_apply(in_word));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing outstanding: %h", out_word);
          fails++;
        end else begin
          want = results_due.pop_front();
          check_field("status",    want.status,    out_word.status);
          check_field("present",   want.present,   out_word.present);
          check_field("count",     want.count,     out_word.count);
          check_field("row_value", want.row_value, out_word.row_value);
          check_field("row_valid", want.row_valid, out_word.row_valid);
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_OPS   = 250;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  sks_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_ready;
  sks_pkg::out_word_t out_word;

  int fails;
  int pending;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_reqs;

  sorted_key_set_with_renumber dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  sks_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .fails    (fails),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one operation word and hold it until taken
  task automatic offer_op(input logic [sks_pkg::FUNC_W-1:0] f,
                          input logic [sks_pkg::KEY_W-1:0] k,
                          input logic [sks_pkg::ROW_W-1:0] r);
    sks_pkg::in_word_t w;
    w.func = f;
    w.key  = k;
    w.row  = r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly a narrow band so adds and removes hit held keys, some extremes
  function automatic logic [sks_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 5) return sks_pkg::KEY_W'($urandom_range(24));
    if (r < 7) begin
      return $urandom_range(1) ? sks_pkg::KEY_W'($urandom_range(3))
                               : sks_pkg::KEY_W'($urandom_range(255, 252));
    end
    return sks_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [sks_pkg::FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 45) return sks_pkg::FUNC_ADD;
    if (r < 75) return sks_pkg::FUNC_REMOVE;
    if (r < 96) return sks_pkg::FUNC_QUERY;
    return sks_pkg::FUNC_CLEAR;
  endfunction

  initial begin
    int ph;
    int n;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty set, not-found, renumbering that leaves the key present
    offer_op(sks_pkg::FUNC_QUERY,  8'd0,   4'd0);
    offer_op(sks_pkg::FUNC_REMOVE, 8'd5,   4'd15);
    offer_op(sks_pkg::FUNC_ADD,    8'd10,  4'd0);
    offer_op(sks_pkg::FUNC_ADD,    8'd11,  4'd1);
    offer_op(sks_pkg::FUNC_ADD,    8'd10,  4'd15);
    offer_op(sks_pkg::FUNC_REMOVE, 8'd10,  4'd0);
    offer_op(sks_pkg::FUNC_REMOVE, 8'd10,  4'd0);
    offer_op(sks_pkg::FUNC_CLEAR,  8'd255, 4'd0);
    // fill to the brim with 0, 255 and keys between
    offer_op(sks_pkg::FUNC_ADD,    8'd0,   4'd0);
    offer_op(sks_pkg::FUNC_ADD,    8'd255, 4'd1);
    for (n = 1; n < 15; n++) offer_op(sks_pkg::FUNC_ADD, 8'(n * 17), 4'(n + 1));
    offer_op(sks_pkg::FUNC_ADD,    8'd100, 4'd15);
    offer_op(sks_pkg::FUNC_ADD,    8'd255, 4'd15);
    offer_op(sks_pkg::FUNC_REMOVE, 8'd0,   4'd15);
    offer_op(sks_pkg::FUNC_QUERY,  8'd254, 4'd14);
    offer_op(sks_pkg::FUNC_CLEAR,  8'd0,   4'd3);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (n = 0; n < PHASE_OPS; n++) begin
        if (ph == 0 && n == 120) hold_reqs++;
        offer_op(pick_func(), pick_key(), sks_pkg::ROW_W'($urandom));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
